// ===== hw/rtl/pjpc_pkg.sv =====
// Shared types and constants for the Poisson-kicked predictor-corrector step.
// Field widths, register map, multiply-accumulate control; no dependencies.
`timescale 1ns / 1ps

package pjpc_pkg;

    // Defaults for the top-level parameters
    localparam int POS_WIDTH_DEF    = 48;
    localparam int FRAC_BITS_DEF    = 32;
    localparam int UNIFORM_BITS_DEF = 32;
    localparam int COUNT_WIDTH_DEF  = 17;

    // Fixed field and register widths
    localparam int U_W   = 32;   // uniform code fields
    localparam int CFG_W = 48;   // Q16.32 registers
    localparam int SPW_W = 13;   // steps_per_wait
    localparam int K_W   = 6;    // exponent of the uniform value, 0..32

    // Logarithm and product widths
    localparam int NL2_W = 38;   // -log2 in Q6.32
    localparam int L_W   = 37;   // -ln in Q5.32
    localparam int AMP_W = 53;   // kick amplitude, Q21.32
    localparam int ACC_W = 85;   // widest product: L * jump_scale

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    localparam logic [CFG_W-1:0] TIME_STEP_RST  = 48'd42949673;
    localparam logic [SPW_W-1:0] SPW_RST        = 13'd100;
    localparam logic [CFG_W-1:0] JUMP_SCALE_RST = 48'd4294967296;
    localparam logic [CFG_W-1:0] COMP_RST       = 48'd42949673;

    typedef enum logic [1:0] {
        REG_TIME_STEP  = 2'd0,
        REG_STEPS_WAIT = 2'd1,
        REG_JUMP_SCALE = 2'd2,
        REG_DRIFT_COMP = 2'd3
    } reg_idx_t;

    // Alignment of a partial product in the accumulator
    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_32 = 2'd1,
        SH_64 = 2'd2
    } shift_t;

    // Multiply-accumulate sequences
    typedef enum logic [1:0] {
        PROG_LOG  = 2'd0,   // -log2 to -ln
        PROG_WAIT = 2'd1,   // -ln * steps_per_wait, rounded
        PROG_AMP  = 2'd2    // -ln * jump_scale
    } prog_t;

    typedef struct packed {
        logic   mul_en;     // register a*b and its alignment
        logic   acc_load;   // preset the accumulator
        logic   acc_half;   // preset value is one half (rounding)
        logic   acc_en;     // add the registered product
        shift_t shift;
    } mac_ctrl_t;

endpackage

// ===== hw/rtl/pjpc_item_if.sv =====
// Input channel: valid/ready handshake with the step command payload.
// Depends on pjpc_pkg for default widths.
`timescale 1ns / 1ps

interface pjpc_item_if #(
    parameter int POS_WIDTH = pjpc_pkg::POS_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [POS_WIDTH-1:0]  start_position;
    logic [pjpc_pkg::U_W-1:0]     u_wait;
    logic [pjpc_pkg::U_W-1:0]     u_amp;

    modport source (output valid, cmd, start_position, u_wait, u_amp, input ready);
    modport sink   (input valid, cmd, start_position, u_wait, u_amp, output ready);
endinterface

// ===== hw/rtl/pjpc_result_if.sv =====
// Result channel: valid/ready handshake with position, kick flag and countdown.
// Depends on pjpc_pkg for default widths.
`timescale 1ns / 1ps

interface pjpc_result_if #(
    parameter int POS_WIDTH   = pjpc_pkg::POS_WIDTH_DEF,
    parameter int COUNT_WIDTH = pjpc_pkg::COUNT_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [POS_WIDTH-1:0]  position;
    logic                         kicked;
    logic [COUNT_WIDTH-1:0]       countdown;

    modport source (output valid, position, kicked, countdown, input ready);
    modport sink   (input valid, position, kicked, countdown, output ready);
endinterface

// ===== hw/rtl/pjpc_mac.sv =====
// Shared 32x32 multiplier with registered product and aligned accumulator.
// Depends on pjpc_pkg (mac_ctrl_t, shift_t, ACC_W).
`timescale 1ns / 1ps

module pjpc_mac (
    input  logic                        clk,
    input  pjpc_pkg::mac_ctrl_t         ctrl,
    input  logic [31:0]                 a,
    input  logic [31:0]                 b,
    output logic [63:0]                 prod,
    output logic [pjpc_pkg::ACC_W-1:0]  acc
);

    logic [63:0]                prod_reg;
    pjpc_pkg::shift_t           shift_reg;
    logic [pjpc_pkg::ACC_W-1:0] acc_reg;
    logic [pjpc_pkg::ACC_W-1:0] addend;

    // unregistered product, also used directly by the squaring rounds
    assign prod = 64'(a) * 64'(b);
    assign acc  = acc_reg;

    always_comb
    begin
        case (shift_reg)
            pjpc_pkg::SH_32: addend = pjpc_pkg::ACC_W'(prod_reg) << 32;
            pjpc_pkg::SH_64: addend = pjpc_pkg::ACC_W'(prod_reg) << 64;
            default:         addend = pjpc_pkg::ACC_W'(prod_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg  <= prod;
            shift_reg <= ctrl.shift;
        end
        if (ctrl.acc_load)
            acc_reg <= ctrl.acc_half ? (pjpc_pkg::ACC_W'(1) << 31) : '0;
        else if (ctrl.acc_en)
            acc_reg <= acc_reg + addend;
    end

endmodule

// ===== hw/rtl/poisson_jump_predictor_corrector_step.sv =====
// A step with kick computes two logarithms. One item in flight; ready only when idle.
// Each logarithm: normalisation, 32 squaring rounds on the shared multiplier, then
//   multiply-accumulate operations (2 for ln, 2 for wait, 4 for amplitude) in ST_MUL then ST_ACC.
// Reset (rst_n, async, active low): position and countdown cleared, registers to defaults,
//   no result pending. No clearing pass.
`timescale 1ns / 1ps

module poisson_jump_predictor_corrector_step #(
    parameter int POS_WIDTH    = pjpc_pkg::POS_WIDTH_DEF,
    parameter int FRAC_BITS    = pjpc_pkg::FRAC_BITS_DEF,
    parameter int UNIFORM_BITS = pjpc_pkg::UNIFORM_BITS_DEF,
    parameter int COUNT_WIDTH  = pjpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    pjpc_item_if.sink                         item,
    pjpc_result_if.source                     result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pjpc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pjpc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pjpc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    // ------------------------------------------------------------------
    // Local widths
    // ------------------------------------------------------------------
    // Integer bit for the drift test; beyond the word it is the sign bit.
    localparam int INT_BIT = (FRAC_BITS < POS_WIDTH) ? FRAC_BITS : POS_WIDTH - 1;
    localparam int FMSK_W  = (FRAC_BITS < POS_WIDTH) ? FRAC_BITS : POS_WIDTH;
    // Sum wide enough for position + (amplitude - compensation) without wrap
    localparam int SUM_W   = ((POS_WIDTH > pjpc_pkg::AMP_W + 1) ? POS_WIDTH
                                                                : pjpc_pkg::AMP_W + 1) + 2;
    localparam int SUMH_W  = SUM_W - POS_WIDTH + 1;
    localparam int WAIT_W  = pjpc_pkg::ACC_W - 32;

    localparam logic [pjpc_pkg::U_W-1:0] U_MASK =
        pjpc_pkg::U_W'((33'd1 << UNIFORM_BITS) - 33'd1);
    localparam logic [WAIT_W-1:0] CNT_MAX_W =
        WAIT_W'((64'd1 << COUNT_WIDTH) - 64'd1);
    localparam logic [2:0] NORM_LAST = 3'd4;
    localparam logic [4:0] SQ_LAST   = 5'd31;

    // ------------------------------------------------------------------
    // Sequencer states
    // ------------------------------------------------------------------
    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_P1      = 13'b0000000000010,   // predictor
        ST_P2      = 13'b0000000000100,   // corrected predictor
        ST_PY      = 13'b0000000001000,   // corrector
        ST_FIN     = 13'b0000000010000,   // kick / compensation
        ST_LN_INIT = 13'b0000000100000,
        ST_NORM    = 13'b0000001000000,
        ST_SQ      = 13'b0000010000000,
        ST_NL2     = 13'b0000100000000,
        ST_MUL     = 13'b0001000000000,
        ST_ACC     = 13'b0010000000000,
        ST_MDONE   = 13'b0100000000000,
        ST_DONE    = 13'b1000000000000
    } state_t;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // -1 drift: even integer part with nonzero fraction (sin(pi x) > 0)
    function automatic logic drift_neg(input logic [POS_WIDTH-1:0] x);
        return !x[INT_BIT] && (x[FMSK_W-1:0] != '0);
    endfunction

    // (da + db)/2 * dt for drifts of +-1
    function automatic logic [SUM_W-1:0] half_term(input logic na, input logic nb,
                                                   input logic [SUM_W-1:0] dt);
        if (na != nb)
            return '0;
        return na ? -dt : dt;
    endfunction

    // base + t1 + t2, clamped to the signed position range
    function automatic logic [POS_WIDTH-1:0] sat_sum(input logic [POS_WIDTH-1:0] base,
                                                     input logic [SUM_W-1:0] t1,
                                                     input logic [SUM_W-1:0] t2);
        logic [SUM_W-1:0]  s;
        logic [SUMH_W-1:0] hi;
        s  = {{(SUM_W - POS_WIDTH){base[POS_WIDTH-1]}}, base} + t1 + t2;
        hi = s[SUM_W-1:POS_WIDTH-1];
        if (hi == '0 || hi == '1)
            return s[POS_WIDTH-1:0];
        return s[SUM_W-1] ? {1'b1, {(POS_WIDTH-1){1'b0}}} : {1'b0, {(POS_WIDTH-1){1'b1}}};
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                          state_reg, state_next;
    logic [2:0]                      idx_reg, idx_next;      // normalise step / mac op
    logic [4:0]                      iter_reg, iter_next;    // squaring round
    logic                            ln_amp_reg, ln_amp_next;
    logic                            kick_reg, kick_next;
    pjpc_pkg::prog_t                 prog_reg, prog_next;

    logic [POS_WIDTH-1:0]            pos_reg, pos_next;      // particle position
    logic [COUNT_WIDTH-1:0]          cnt_reg, cnt_next;      // kick countdown

    logic [POS_WIDTH-1:0]            tmp_reg, tmp_next;      // predictor / corrector
    logic [pjpc_pkg::U_W-1:0]        u_wait_reg, u_wait_next;
    logic [pjpc_pkg::U_W-1:0]        u_amp_reg, u_amp_next;
    logic [31:0]                     z_reg, z_next;          // Q1.31 mantissa
    logic [pjpc_pkg::K_W-1:0]        k_reg, k_next;          // exponent
    logic [31:0]                     frac_reg, frac_next;    // log2 fraction bits
    logic [pjpc_pkg::NL2_W-1:0]      nl2_reg, nl2_next;
    logic [pjpc_pkg::L_W-1:0]        l_reg, l_next;
    logic [pjpc_pkg::AMP_W-1:0]      amp_reg, amp_next;

    logic                            res_valid_reg;
    logic [POS_WIDTH-1:0]            res_pos_reg;
    logic                            res_kick_reg;
    logic [COUNT_WIDTH-1:0]          res_cnt_reg;

    logic [pjpc_pkg::CFG_W-1:0]      ts_reg;
    logic [pjpc_pkg::SPW_W-1:0]      spw_reg;
    logic [pjpc_pkg::CFG_W-1:0]      js_reg;
    logic [pjpc_pkg::CFG_W-1:0]      comp_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[4:3])
            pjpc_pkg::REG_TIME_STEP:  prdata = pjpc_pkg::APB_DATA_W'(ts_reg);
            pjpc_pkg::REG_STEPS_WAIT: prdata = pjpc_pkg::APB_DATA_W'(spw_reg);
            pjpc_pkg::REG_JUMP_SCALE: prdata = pjpc_pkg::APB_DATA_W'(js_reg);
            pjpc_pkg::REG_DRIFT_COMP: prdata = pjpc_pkg::APB_DATA_W'(comp_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg   <= pjpc_pkg::TIME_STEP_RST;
            spw_reg  <= pjpc_pkg::SPW_RST;
            js_reg   <= pjpc_pkg::JUMP_SCALE_RST;
            comp_reg <= pjpc_pkg::COMP_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:3])
                pjpc_pkg::REG_TIME_STEP:  ts_reg   <= pwdata[pjpc_pkg::CFG_W-1:0];
                pjpc_pkg::REG_STEPS_WAIT: spw_reg  <= pwdata[pjpc_pkg::SPW_W-1:0];
                pjpc_pkg::REG_JUMP_SCALE: js_reg   <= pwdata[pjpc_pkg::CFG_W-1:0];
                pjpc_pkg::REG_DRIFT_COMP: comp_reg <= pwdata[pjpc_pkg::CFG_W-1:0];
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier / accumulator
    // ------------------------------------------------------------------
    pjpc_pkg::mac_ctrl_t             mac_ctrl;
    logic [31:0]                     mac_a, mac_b;
    logic [63:0]                     mac_prod;
    logic [pjpc_pkg::ACC_W-1:0]      mac_acc;

    pjpc_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .a    (mac_a),
        .b    (mac_b),
        .prod (mac_prod),
        .acc  (mac_acc)
    );

    // Operand table of the multiply-accumulate sequences.
    //   LOG : nl2 * ln2        (low word, then high word << 32)
    //   WAIT: L * spw + 1/2    (low word, then high word << 32)
    //   AMP : L * jump_scale   (four partial products)
    logic [31:0]      op_a, op_b;
    pjpc_pkg::shift_t op_sh;
    logic             op_last;

    always_comb
    begin
        op_a    = '0;
        op_b    = '0;
        op_sh   = pjpc_pkg::SH_0;
        op_last = 1'b0;
        unique case (prog_reg)
            pjpc_pkg::PROG_LOG:
            begin
                op_b = pjpc_pkg::LN2_Q32;
                if (idx_reg[0])
                begin
                    op_a    = 32'(nl2_reg[pjpc_pkg::NL2_W-1:32]);
                    op_sh   = pjpc_pkg::SH_32;
                    op_last = 1'b1;
                end
                else
                    op_a = nl2_reg[31:0];
            end
            pjpc_pkg::PROG_WAIT:
            begin
                op_b = 32'(spw_reg);
                if (idx_reg[0])
                begin
                    op_a    = 32'(l_reg[pjpc_pkg::L_W-1:32]);
                    op_sh   = pjpc_pkg::SH_32;
                    op_last = 1'b1;
                end
                else
                    op_a = l_reg[31:0];
            end
            pjpc_pkg::PROG_AMP:
            begin
                op_a = idx_reg[1] ? 32'(l_reg[pjpc_pkg::L_W-1:32]) : l_reg[31:0];
                op_b = idx_reg[0] ? 32'(js_reg[pjpc_pkg::CFG_W-1:32]) : js_reg[31:0];
                if (idx_reg[1:0] == 2'd3)
                begin
                    op_sh   = pjpc_pkg::SH_64;
                    op_last = 1'b1;
                end
                else if (idx_reg[1:0] != 2'd0)
                    op_sh = pjpc_pkg::SH_32;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Saturating position adder, shared by the three evaluations and the
    // final kick/compensation
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]     dt_w;
    logic                 d0_neg, dtmp_neg;
    logic [POS_WIDTH-1:0] add_base;
    logic [SUM_W-1:0]     add_t1, add_t2;
    logic [POS_WIDTH-1:0] add_sum;

    assign dt_w     = SUM_W'(ts_reg);
    assign d0_neg   = drift_neg(pos_reg);
    assign dtmp_neg = drift_neg(tmp_reg);

    always_comb
    begin
        add_base = pos_reg;
        add_t1   = '0;
        add_t2   = '0;
        unique case (state_reg)
            ST_P1:        add_t1 = half_term(d0_neg, d0_neg, dt_w);
            ST_P2, ST_PY: add_t1 = half_term(d0_neg, dtmp_neg, dt_w);
            ST_FIN:
            begin
                add_base = tmp_reg;
                add_t1   = kick_reg ? SUM_W'(amp_reg) : '0;
                add_t2   = -(SUM_W'(comp_reg));
            end
            default: ;
        endcase
    end

    assign add_sum = sat_sum(add_base, add_t1, add_t2);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic                      res_load;
    logic [pjpc_pkg::U_W-1:0]  ln_code;
    logic [32:0]               ln_m;
    logic [5:0]                norm_s;
    logic [32:0]               sq_t;
    logic [WAIT_W-1:0]         wait_full;

    assign item.ready = (state_reg == ST_IDLE);
    assign res_load   = (state_reg == ST_DONE) && (!res_valid_reg || result.ready);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        iter_next   = iter_reg;
        ln_amp_next = ln_amp_reg;
        kick_next   = kick_reg;
        prog_next   = prog_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        tmp_next    = tmp_reg;
        u_wait_next = u_wait_reg;
        u_amp_next  = u_amp_reg;
        z_next      = z_reg;
        k_next      = k_reg;
        frac_next   = frac_reg;
        nl2_next    = nl2_reg;
        l_next      = l_reg;
        amp_next    = amp_reg;
        mac_ctrl    = '0;
        mac_a       = op_a;
        mac_b       = op_b;

        ln_code   = ln_amp_reg ? u_amp_reg : u_wait_reg;
        ln_m      = {1'b0, ln_code & U_MASK} + 33'd1;
        norm_s    = 6'd16 >> idx_reg;
        sq_t      = mac_prod[63:31];
        wait_full = mac_acc[pjpc_pkg::ACC_W-1:32];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    kick_next   = item.cmd && (cnt_reg == '0);
                    u_wait_next = item.u_wait;
                    u_amp_next  = item.u_amp;
                    ln_amp_next = 1'b0;
                    if (item.cmd)
                        state_next = ST_P1;
                    else
                    begin
                        pos_next   = item.start_position;
                        state_next = ST_LN_INIT;
                    end
                end
            end
            ST_P1:
            begin
                tmp_next   = add_sum;
                state_next = ST_P2;
            end
            ST_P2:
            begin
                tmp_next   = add_sum;
                state_next = ST_PY;
            end
            ST_PY:
            begin
                tmp_next = add_sum;
                if (kick_reg)
                begin
                    // amplitude first, it is needed by the final sum
                    ln_amp_next = 1'b1;
                    state_next  = ST_LN_INIT;
                end
                else
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                pos_next = add_sum;
                if (kick_reg)
                begin
                    ln_amp_next = 1'b0;
                    state_next  = ST_LN_INIT;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_LN_INIT:
            begin
                // m = c + 1; the full-scale value 2^32 is already a power of two
                if (ln_m[32])
                begin
                    z_next = 32'h8000_0000;
                    k_next = pjpc_pkg::K_W'(32);
                end
                else
                begin
                    z_next = ln_m[31:0];
                    k_next = pjpc_pkg::K_W'(31);
                end
                frac_next  = '0;
                idx_next   = '0;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                // binary search for the leading one: 16, 8, 4, 2, 1
                if ((z_reg >> (6'd32 - norm_s)) == '0)
                begin
                    z_next = z_reg << norm_s;
                    k_next = k_reg - norm_s;
                end
                if (idx_reg == NORM_LAST)
                begin
                    iter_next  = '0;
                    state_next = ST_SQ;
                end
                else
                    idx_next = idx_reg + 3'd1;
            end
            ST_SQ:
            begin
                // one fraction bit of log2 per squaring
                mac_a     = z_reg;
                mac_b     = z_reg;
                frac_next = {frac_reg[30:0], sq_t[32]};
                z_next    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
                if (iter_reg == SQ_LAST)
                    state_next = ST_NL2;
                else
                    iter_next = iter_reg + 5'd1;
            end
            ST_NL2:
            begin
                nl2_next = {pjpc_pkg::K_W'(UNIFORM_BITS) - k_reg, 32'd0}
                         - pjpc_pkg::NL2_W'(frac_reg);
                prog_next         = pjpc_pkg::PROG_LOG;
                idx_next          = '0;
                mac_ctrl.acc_load = 1'b1;
                state_next        = ST_MUL;
            end
            ST_MUL:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.shift  = op_sh;
                state_next      = ST_ACC;
            end
            ST_ACC:
            begin
                mac_ctrl.acc_en = 1'b1;
                if (op_last)
                    state_next = ST_MDONE;
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = ST_MUL;
                end
            end
            ST_MDONE:
            begin
                unique case (prog_reg)
                    pjpc_pkg::PROG_LOG:
                    begin
                        l_next            = mac_acc[pjpc_pkg::L_W+31:32];
                        prog_next         = ln_amp_reg ? pjpc_pkg::PROG_AMP
                                                       : pjpc_pkg::PROG_WAIT;
                        mac_ctrl.acc_load = 1'b1;
                        mac_ctrl.acc_half = !ln_amp_reg;
                        idx_next          = '0;
                        state_next        = ST_MUL;
                    end
                    pjpc_pkg::PROG_AMP:
                    begin
                        amp_next   = mac_acc[pjpc_pkg::ACC_W-1:32];
                        state_next = ST_FIN;
                    end
                    pjpc_pkg::PROG_WAIT:
                    begin
                        cnt_next   = (wait_full > CNT_MAX_W) ? CNT_MAX_W[COUNT_WIDTH-1:0]
                                                            : wait_full[COUNT_WIDTH-1:0];
                        state_next = ST_DONE;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_DONE:
            begin
                if (res_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and particle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            iter_reg      <= '0;
            ln_amp_reg    <= 1'b0;
            kick_reg      <= 1'b0;
            prog_reg      <= pjpc_pkg::PROG_LOG;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            iter_reg   <= iter_next;
            ln_amp_reg <= ln_amp_next;
            kick_reg   <= kick_next;
            prog_reg   <= prog_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        tmp_reg    <= tmp_next;
        u_wait_reg <= u_wait_next;
        u_amp_reg  <= u_amp_next;
        z_reg      <= z_next;
        k_reg      <= k_next;
        frac_reg   <= frac_next;
        nl2_reg    <= nl2_next;
        l_reg      <= l_next;
        amp_reg    <= amp_next;
        if (res_load)
        begin
            res_pos_reg  <= pos_reg;
            res_kick_reg <= kick_reg;
            res_cnt_reg  <= cnt_reg;
        end
    end

    assign result.valid     = res_valid_reg;
    assign result.position  = res_pos_reg;
    assign result.kicked    = res_kick_reg;
    assign result.countdown = res_cnt_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NORM && idx_reg == NORM_LAST) |=> z_reg[31])
        else $error("mantissa not normalised after leading-one search");

    a_sq_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ) |-> z_reg[31])
        else $error("squaring round left mantissa outside [1,2)");

    a_count_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && !kick_reg) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("countdown not decremented on a step without kick");

    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside completion");

endmodule
